// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property with reset disabling it.
`define CHK_PROP(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("property failed");

// Check a property at every edge, reset included.
`define CHK_PROP_ALL(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("property failed");

`endif

// ----- hdl/slc_pkg.sv -----
// Shared types and codes for the set-associative LRU cache lookup.
// Depends on nothing.
`default_nettype none
package slc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_NONE  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  // Front queue head status toward the back end.
  typedef struct packed {
    logic valid;
    logic dbl;
  } fq_ctrl_t;

  // Back end control toward the front.
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctrl_t;

  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_RST       = 4'd8;
  localparam logic [5:0] BLOCK_BITS_MAX = 6'd32;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ----- hdl/set_assoc_lru_cache_lookup_top.sv -----
// Top level of the set-associative LRU cache lookup: config registers,
// front queue and back end. Depends on slc_pkg, slc_front, slc_back.
//
//   channel   handshake        payload
//   access    push / full      operation, address
//   result    pop / empty      access_outcome, last_of_run, *_total
//   config    cfg_we           cfg_index, cfg_data
//
// Each access in the back end is a set row read, then the LRU update and
// row write. Load and store are popped after this pass; a modify item runs it again first.
// After reset a clearing pass writes every set row, with full held high.
// A 2-entry queue takes items while a result waits; the back end starts
// an access only with the result slot free or being popped.
`default_nettype none
module set_assoc_lru_cache_lookup_top #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            operation,
  input  wire logic [ADDR_WIDTH-1:0] address,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [1:0]                 access_outcome,
  output logic                       last_of_run,
  output logic [31:0]                hit_total,
  output logic [31:0]                miss_total,
  output logic [31:0]                eviction_total,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [5:0]            cfg_data
);
  logic [3:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_in_use;

  slc_pkg::fq_ctrl_t       q;
  slc_pkg::bk_ctrl_t       bk;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [ADDR_WIDTH-3:0]   q_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= slc_pkg::SET_BITS_RST;
      block_bits  <= slc_pkg::BLOCK_BITS_RST;
      ways_in_use <= slc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slc_pkg::CFG_SET_BITS:   set_bits    <= cfg_data[3:0];
        slc_pkg::CFG_BLOCK_BITS: block_bits  <= cfg_data;
        slc_pkg::CFG_WAYS:       ways_in_use <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  slc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .address   (address),
    .set_bits  (set_bits),
    .block_bits(block_bits),
    .q         (q),
    .q_set     (q_set),
    .q_tag     (q_tag),
    .bk        (bk)
  );

  slc_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q             (q),
    .q_set         (q_set),
    .q_tag         (q_tag),
    .bk            (bk),
    .ways_in_use   (ways_in_use),
    .empty         (empty),
    .pop           (pop),
    .access_outcome(access_outcome),
    .last_of_run   (last_of_run),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .eviction_total(eviction_total)
  );
endmodule
`default_nettype wire

// ----- hdl/slc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/slc_front.sv -----
// Front end: accepts access items, splits the address, queues them.
// Depends on slc_pkg.
`default_nettype none
module slc_front #(
  parameter int MAX_SET_BITS = 10,
  parameter int ADDR_WIDTH   = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 operation,
  input  wire logic [ADDR_WIDTH-1:0]      address,
  input  wire logic [3:0]                 set_bits,
  input  wire logic [5:0]                 block_bits,
  output slc_pkg::fq_ctrl_t               q,
  output logic [MAX_SET_BITS-1:0]         q_set,
  output logic [ADDR_WIDTH-3:0]           q_tag,
  input  wire slc_pkg::bk_ctrl_t          bk
);
  localparam int TW = ADDR_WIDTH - 2;

  logic [4:0]              s;
  logic [5:0]              b;
  logic [6:0]              bs;
  logic [ADDR_WIDTH-1:0]   shifted;
  logic [ADDR_WIDTH-1:0]   tag_full;
  logic [MAX_SET_BITS-1:0] mask;
  logic [MAX_SET_BITS-1:0] set_in;
  logic                    accept;

  logic                    ent_dbl [2];
  logic [MAX_SET_BITS-1:0] ent_set [2];
  logic [TW-1:0]           ent_tag [2];
  logic                    wptr;
  logic                    rptr;
  logic [1:0]              cnt;

  always_comb begin
    if (set_bits == 4'd0) begin
      s = 5'd1;
    end else if (5'(set_bits) > 5'(MAX_SET_BITS)) begin
      s = 5'(MAX_SET_BITS);
    end else begin
      s = 5'(set_bits);
    end
    if (block_bits == 6'd0) begin
      b = 6'd1;
    end else if (block_bits > slc_pkg::BLOCK_BITS_MAX) begin
      b = slc_pkg::BLOCK_BITS_MAX;
    end else begin
      b = block_bits;
    end
    bs       = 7'(b) + 7'(s);
    shifted  = address >> b;
    tag_full = address >> bs;
    mask     = ~({MAX_SET_BITS{1'b1}} << s);
    set_in   = shifted[MAX_SET_BITS-1:0] & mask;
  end

  assign full   = (cnt == 2'd2) || bk.clearing;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_dbl[wptr] <= (operation == slc_pkg::OP_MODIFY);
      ent_set[wptr] <= set_in;
      ent_tag[wptr] <= tag_full[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (bk.pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(accept) - 2'(bk.pop);
    end
  end

  assign q     = {(cnt != 2'd0), ent_dbl[rptr]};
  assign q_set = ent_set[rptr];
  assign q_tag = ent_tag[rptr];
endmodule
`default_nettype wire

// ----- hdl/slc_back.sv -----
// Back end: set read-modify-write with LRU update, totals, result register.
// Depends on slc_pkg and slc_ram.
`default_nettype none
module slc_back #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire slc_pkg::fq_ctrl_t     q,
  input  wire logic [MAX_SET_BITS-1:0] q_set,
  input  wire logic [ADDR_WIDTH-3:0] q_tag,
  output slc_pkg::bk_ctrl_t          bk,
  input  wire logic [3:0]            ways_in_use,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [1:0]                 access_outcome,
  output logic                       last_of_run,
  output logic [31:0]                hit_total,
  output logic [31:0]                miss_total,
  output logic [31:0]                eviction_total
);
  localparam int TW    = ADDR_WIDTH - 2;
  localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WW    = RW;
  localparam int ROW_W = MAX_WAYS * (1 + TW + RW);
  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam logic [RW-1:0] CAP = RW'(MAX_WAYS - 1);

  slc_pkg::bk_state_t state, state_next;
  logic [MAX_SET_BITS-1:0] clr_cnt;
  logic                    phase;
  logic                    out_valid;
  logic [31:0]             hits, misses, evicts;

  logic               ram_we, ram_re;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]   ram_wdata, row;

  logic [4:0]         ways;
  logic [MAX_WAYS-1:0] v, v_new;
  logic [TW-1:0]      tg [MAX_WAYS];
  logic [RW-1:0]      rk [MAX_WAYS];
  logic [TW-1:0]      tg_new [MAX_WAYS];
  logic [RW-1:0]      rk_new [MAX_WAYS];
  logic               hit, inv;
  logic [WW-1:0]      hw, iw, vw, w;
  logic [RW-1:0]      old;
  logic [RW:0]        limit;
  slc_pkg::outcome_t  outcome;
  logic               start;

  slc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(q_set),
    .rdata(row)
  );

  always_comb begin
    if (ways_in_use == 4'd0) begin
      ways = 5'd1;
    end else if (5'(ways_in_use) > 5'(MAX_WAYS)) begin
      ways = 5'(MAX_WAYS);
    end else begin
      ways = 5'(ways_in_use);
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      v[j]  = row[MAX_WAYS*(RW+TW) + j];
      tg[j] = row[MAX_WAYS*RW + j*TW +: TW];
      rk[j] = row[j*RW +: RW];
    end
    hit = 1'b0;
    hw  = '0;
    inv = 1'b0;
    iw  = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (!hit && j < int'(ways) && v[j] && tg[j] == q_tag) begin
        hit = 1'b1;
        hw  = WW'(j);
      end
      if (!inv && j < int'(ways) && !v[j]) begin
        inv = 1'b1;
        iw  = WW'(j);
      end
    end
    vw  = '0;
    old = rk[0];
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (j < int'(ways) && rk[j] > old) begin
        old = rk[j];
        vw  = WW'(j);
      end
    end
    if (hit) begin
      w       = hw;
      limit   = {1'b0, rk[hw]};
      outcome = slc_pkg::OUT_HIT;
    end else if (inv) begin
      w       = iw;
      limit   = (RW+1)'(MAX_WAYS);
      outcome = slc_pkg::OUT_FILL;
    end else begin
      w       = vw;
      limit   = {1'b0, old};
      outcome = slc_pkg::OUT_EVICT;
    end
    v_new = v;
    for (int j = 0; j < MAX_WAYS; j++) begin
      tg_new[j] = tg[j];
      rk_new[j] = rk[j];
      if (WW'(j) == w) begin
        rk_new[j] = '0;
        v_new[j]  = 1'b1;
        if (!hit) begin
          tg_new[j] = q_tag;
        end
      end else if (j < int'(ways) && v[j] && {1'b0, rk[j]} < limit && rk[j] != CAP) begin
        rk_new[j] = rk[j] + 1'b1;
      end
    end
  end

  assign start    = q.valid && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = q_set;
    ram_wdata   = '0;
    bk.pop      = 1'b0;
    bk.clearing = (state == slc_pkg::BK_CLEAR);
    for (int j = 0; j < MAX_WAYS; j++) begin
      ram_wdata[MAX_WAYS*(RW+TW) + j]         = v_new[j];
      ram_wdata[MAX_WAYS*RW + j*TW +: TW]     = tg_new[j];
      ram_wdata[j*RW +: RW]                   = rk_new[j];
    end
    case (state)
      slc_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (&clr_cnt) begin
          state_next = slc_pkg::BK_IDLE;
        end
      end
      slc_pkg::BK_IDLE: begin
        if (start) begin
          ram_re     = 1'b1;
          state_next = slc_pkg::BK_EXEC;
        end
      end
      slc_pkg::BK_EXEC: begin
        ram_we     = 1'b1;
        bk.pop     = !(q.dbl && !phase);
        state_next = slc_pkg::BK_IDLE;
      end
      default: begin
        state_next = slc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slc_pkg::BK_CLEAR;
      clr_cnt   <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
      hits      <= '0;
      misses    <= '0;
      evicts    <= '0;
    end else begin
      state <= state_next;
      if (state == slc_pkg::BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == slc_pkg::BK_EXEC) begin
        out_valid <= 1'b1;
        phase     <= q.dbl && !phase;
        if (hit) begin
          if (hits != slc_pkg::COUNT_MAX) hits <= hits + 32'd1;
        end else begin
          if (misses != slc_pkg::COUNT_MAX) misses <= misses + 32'd1;
          if (!inv && evicts != slc_pkg::COUNT_MAX) evicts <= evicts + 32'd1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == slc_pkg::BK_EXEC) begin
      access_outcome <= outcome;
      last_of_run    <= !(q.dbl && !phase);
      hit_total      <= (hit && hits != slc_pkg::COUNT_MAX) ? hits + 32'd1 : hits;
      miss_total     <= (!hit && misses != slc_pkg::COUNT_MAX) ? misses + 32'd1 : misses;
      eviction_total <= (!hit && !inv && evicts != slc_pkg::COUNT_MAX) ?
                        evicts + 32'd1 : evicts;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/slc_checker.sv -----
// Port-level checks for the cache lookup top, attached by bind.
// Depends on slc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module slc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  access_outcome,
  input wire logic [31:0] hit_total
);
  `CHK_PROP_ALL(a_empty_after_rst, clk, rst |=> empty)
  `CHK_PROP_ALL(a_full_during_clear, clk, rst |=> full)
  `CHK_PROP(a_outcome_legal, clk, rst, !empty |-> access_outcome != slc_pkg::OUT_NONE)
  `CHK_PROP(a_result_held, clk, rst, (!empty && !pop) |=> (!empty && $stable(hit_total)))
endmodule

bind set_assoc_lru_cache_lookup_top slc_checker u_slc_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .access_outcome(access_outcome),
  .hit_total     (hit_total)
);
`default_nettype wire
